FILE: rtl/core/qlsf_pkg.sv
// shared types, constants and the determinant step table for the quadratic fit unit
// no dependencies; imported by every module of the block
package qlsf_pkg;

   localparam int MAX_POINTS_DEF = 256;

   // input queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // solver datapath
   localparam int WIDE_W     = 128;
   localparam int ELEM_W     = 64;
   localparam int MUL_STEPS  = 64;
   localparam int DIV_STEPS  = 128;
   localparam int ITER_W     = 7;
   localparam int NUM_STEPS  = 9;
   localparam int STEP_W     = 4;

   localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [31:0] SAT_NEG = 32'h8000_0000;

   // step operations
   localparam logic [2:0] OP_C_SET = 3'd0;
   localparam logic [2:0] OP_C_SUB = 3'd1;
   localparam logic [2:0] OP_D_SET = 3'd2;
   localparam logic [2:0] OP_D_SUB = 3'd3;
   localparam logic [2:0] OP_D_ADD = 3'd4;

   typedef struct packed {
      logic signed [11:0] x_value;
      logic signed [15:0] y_value;
      logic               last;
   } req_item_type;

   typedef struct packed {
      logic signed [31:0] coef_a2;
      logic signed [31:0] coef_a1;
      logic signed [31:0] coef_a0;
      logic               singular;
      logic               saturated;
   } rsp_item_type;

   typedef struct packed {
      logic              start;
      logic              is_div;
      logic [WIDE_W-1:0] a;
      logic [WIDE_W-1:0] b;
   } mdu_req_type;

   typedef struct packed {
      logic              done;
      logic [WIDE_W-1:0] result;
   } mdu_rsp_type;

   typedef struct packed {
      logic       a_cof;
      logic [1:0] a_row;
      logic [1:0] a_col;
      logic [1:0] b_row;
      logic [1:0] b_col;
      logic [2:0] op;
   } step_type;

   // cofactor expansion of a 3x3 determinant along the first row
   function automatic step_type step_entry(input logic [STEP_W-1:0] idx);
      step_type s;
      s = '0;
      case (idx)
         4'd0: s = '{1'b0, 2'd1, 2'd1, 2'd2, 2'd2, OP_C_SET};
         4'd1: s = '{1'b0, 2'd1, 2'd2, 2'd2, 2'd1, OP_C_SUB};
         4'd2: s = '{1'b1, 2'd0, 2'd0, 2'd0, 2'd0, OP_D_SET};
         4'd3: s = '{1'b0, 2'd1, 2'd0, 2'd2, 2'd2, OP_C_SET};
         4'd4: s = '{1'b0, 2'd1, 2'd2, 2'd2, 2'd0, OP_C_SUB};
         4'd5: s = '{1'b1, 2'd0, 2'd0, 2'd0, 2'd1, OP_D_SUB};
         4'd6: s = '{1'b0, 2'd1, 2'd0, 2'd2, 2'd1, OP_C_SET};
         4'd7: s = '{1'b0, 2'd1, 2'd1, 2'd2, 2'd0, OP_C_SUB};
         4'd8: s = '{1'b1, 2'd0, 2'd0, 2'd0, 2'd2, OP_D_ADD};
         default: s = '0;
      endcase
      return s;
   endfunction

endpackage

FILE: rtl/core/qlsf_front.sv
// front end: accepts sample words into a short queue for the back end
// depends on qlsf_pkg
module qlsf_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  qlsf_pkg::req_item_type req_item,
   output logic                  head_valid,
   output qlsf_pkg::req_item_type head_item,
   input  logic                  take
);
   import qlsf_pkg::*;

   req_item_type     slot_ff [0:QUEUE_DEPTH-1];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push_ok;
   logic              pop_ok;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = slot_ff[rd_ptr_ff];
   assign push_ok    = push && !full;
   assign pop_ok     = take && head_valid;

   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= req_item;
      end
   end

endmodule

FILE: rtl/core/qlsf_mdu.sv
// shared iterative unit: shift-add multiply (one bit a cycle) and restoring divide
// depends on qlsf_pkg
module qlsf_mdu (
   input  logic                 clock,
   input  logic                 reset,
   input  qlsf_pkg::mdu_req_type req,
   output qlsf_pkg::mdu_rsp_type rsp
);
   import qlsf_pkg::*;

   localparam logic [ITER_W-1:0] MUL_LAST = ITER_W'(MUL_STEPS - 1);
   localparam logic [ITER_W-1:0] DIV_LAST = ITER_W'(DIV_STEPS - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              div_ff, div_in;
   logic [ITER_W-1:0] cnt_ff, cnt_in;
   logic [WIDE_W-1:0] acc_ff, acc_in;
   logic [WIDE_W-1:0] opa_ff, opa_in;
   logic [WIDE_W-1:0] opb_ff, opb_in;
   logic [WIDE_W-1:0] trial;
   logic [WIDE_W:0]   diff;
   logic              top_bit;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      opa_in  = opa_ff;
      opb_in  = opb_ff;
      top_bit = opb_ff[WIDE_W-1];
      trial   = {acc_ff[WIDE_W-2:0], top_bit};
      diff    = {1'b0, trial} - {1'b0, opa_ff};
      if (req.start) begin
         busy_in = 1'b1;
         div_in  = req.is_div;
         cnt_in  = '0;
         acc_in  = '0;
         opa_in  = req.a;
         opb_in  = req.is_div ? req.b : {req.b[ELEM_W-1:0], {(WIDE_W-ELEM_W){1'b0}}};
      end else if (busy_ff) begin
         if (div_ff) begin
            acc_in = diff[WIDE_W] ? trial : diff[WIDE_W-1:0];
            opb_in = {opb_ff[WIDE_W-2:0], !diff[WIDE_W]};
         end else begin
            acc_in = {acc_ff[WIDE_W-2:0], 1'b0} + (top_bit ? opa_ff : '0);
            opb_in = {opb_ff[WIDE_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == (div_ff ? DIV_LAST : MUL_LAST)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign rsp.done   = done_ff;
   assign rsp.result = div_ff ? opb_ff : acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      opa_ff <= opa_in;
      opb_ff <= opb_in;
   end

endmodule

FILE: rtl/core/qlsf_back.sv
// back end: accumulates the power sums and sequences the cramer solve
// depends on qlsf_pkg; drives qlsf_mdu through a request/response struct pair
module qlsf_back #(
   parameter int MAX_POINTS = qlsf_pkg::MAX_POINTS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_valid,
   input  qlsf_pkg::req_item_type item,
   output logic                   item_take,
   input  logic [31:0]            det_threshold,
   output qlsf_pkg::mdu_req_type  mdu_req,
   input  qlsf_pkg::mdu_rsp_type  mdu_rsp,
   output logic                   res_valid,
   output qlsf_pkg::rsp_item_type res_item,
   input  logic                   res_free
);
   import qlsf_pkg::*;

   localparam int CNT_W = $clog2(MAX_POINTS + 1);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_ACC1   = 4'd1;
   localparam logic [3:0] S_ACC2   = 4'd2;
   localparam logic [3:0] S_MSTART = 4'd3;
   localparam logic [3:0] S_MWAIT  = 4'd4;
   localparam logic [3:0] S_DABS   = 4'd5;
   localparam logic [3:0] S_DCHK   = 4'd6;
   localparam logic [3:0] S_NABS   = 4'd7;
   localparam logic [3:0] S_DWAIT  = 4'd8;
   localparam logic [3:0] S_EMIT   = 4'd9;

   logic [3:0]        state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic signed [19:0] sx_ff, sx_in;
   logic signed [31:0] sxx_ff, sxx_in;
   logic signed [43:0] sxxx_ff, sxxx_in;
   logic signed [55:0] sxxxx_ff, sxxxx_in;
   logic signed [23:0] sy_ff, sy_in;
   logic signed [35:0] sxy_ff, sxy_in;
   logic signed [47:0] sxxy_ff, sxxy_in;

   logic signed [11:0] x_ff, x_in;
   logic signed [15:0] y_ff, y_in;
   logic               last_ff, last_in;
   logic signed [23:0] x2_ff, x2_in;
   logic signed [27:0] xy_ff, xy_in;
   logic signed [35:0] x3;
   logic signed [47:0] x4;
   logic signed [39:0] x2y;

   logic [1:0]         k_ff, k_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [WIDE_W-1:0]  cof_ff, cof_in;
   logic [WIDE_W-1:0]  det_ff, det_in;
   logic [WIDE_W-1:0]  dabs_ff, dabs_in;
   logic               dneg_ff, dneg_in;
   logic               qneg_ff, qneg_in;
   logic [31:0]        a2_ff, a2_in, a1_ff, a1_in, a0_ff, a0_in;
   logic               sat_ff, sat_in, sing_ff, sing_in;

   logic signed [ELEM_W-1:0] m [0:2][0:2];
   logic signed [ELEM_W-1:0] bv [0:2];
   logic signed [ELEM_W-1:0] t_elem [0:3][0:3];
   logic signed [ELEM_W-1:0] a_elem, b_elem;
   logic [WIDE_W-1:0]  a_ext, a_src;
   logic [ELEM_W-1:0]  b_mag;
   logic               b_neg;
   step_type           cur;
   logic [WIDE_W-1:0]  num, prod, quo;
   logic [31:0]        cval;
   logic               csat;

   assign x3  = x2_ff * x_ff;
   assign x4  = x2_ff * x2_ff;
   assign x2y = x2_ff * y_ff;

   // matrix of the normal equations, one column swapped for the rhs when k is nonzero
   always_comb begin
      m[0][0] = 64'(sxxxx_ff); m[0][1] = 64'(sxxx_ff); m[0][2] = 64'(sxx_ff);
      m[1][0] = 64'(sxxx_ff);  m[1][1] = 64'(sxx_ff);  m[1][2] = 64'(sx_ff);
      m[2][0] = 64'(sxx_ff);   m[2][1] = 64'(sx_ff);   m[2][2] = $signed(64'(cnt_ff));
      bv[0]   = 64'(sxxy_ff);  bv[1]   = 64'(sxy_ff);  bv[2]   = 64'(sy_ff);
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            t_elem[r][c] = '0;
         end
      end
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if ((k_ff != 2'd0) && (2'(c) == k_ff - 2'd1)) begin
               t_elem[r][c] = bv[r];
            end else begin
               t_elem[r][c] = m[r][c];
            end
         end
      end
   end

   always_comb begin
      cur    = step_entry(step_ff);
      a_elem = t_elem[cur.a_row][cur.a_col];
      b_elem = t_elem[cur.b_row][cur.b_col];
      a_ext  = 128'(a_elem);
      b_neg  = b_elem[ELEM_W-1];
      a_src  = cur.a_cof ? cof_ff : a_ext;
      b_mag  = b_neg ? 64'(64'sd0 - b_elem) : 64'(b_elem);
      prod   = mdu_rsp.result;
      quo    = mdu_rsp.result;
      case (k_ff)
         2'd1:    num = det_ff << 16;
         2'd2:    num = det_ff << 12;
         default: num = det_ff << 8;
      endcase
   end

   // saturating conversion of the quotient magnitude to q16.16
   always_comb begin
      cval = '0;
      csat = 1'b0;
      if (!qneg_ff) begin
         if (quo[WIDE_W-1:31] != '0) begin
            cval = SAT_POS;
            csat = 1'b1;
         end else begin
            cval = quo[31:0];
         end
      end else if ((quo[WIDE_W-1:32] != '0) || (quo[31:0] > SAT_NEG)) begin
         cval = SAT_NEG;
         csat = 1'b1;
      end else begin
         cval = 32'd0 - quo[31:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      sx_in    = sx_ff;    sxx_in  = sxx_ff;  sxxx_in = sxxx_ff; sxxxx_in = sxxxx_ff;
      sy_in    = sy_ff;    sxy_in  = sxy_ff;  sxxy_in = sxxy_ff;
      x_in     = x_ff;     y_in    = y_ff;    last_in = last_ff;
      x2_in    = x2_ff;    xy_in   = xy_ff;
      k_in     = k_ff;     step_in = step_ff;
      cof_in   = cof_ff;   det_in  = det_ff;
      dabs_in  = dabs_ff;  dneg_in = dneg_ff; qneg_in = qneg_ff;
      a2_in    = a2_ff;    a1_in   = a1_ff;   a0_in   = a0_ff;
      sat_in   = sat_ff;   sing_in = sing_ff;
      item_take = 1'b0;
      mdu_req   = '0;
      res_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (item_valid) begin
               item_take = 1'b1;
               x_in      = item.x_value;
               y_in      = item.y_value;
               last_in   = item.last;
               state_in  = S_ACC1;
            end
         end
         S_ACC1: begin
            x2_in    = x_ff * x_ff;
            xy_in    = x_ff * y_ff;
            state_in = S_ACC2;
         end
         S_ACC2: begin
            if (cnt_ff < CNT_W'(MAX_POINTS)) begin
               cnt_in   = cnt_ff + 1'b1;
               sx_in    = sx_ff + 20'(x_ff);
               sxx_in   = sxx_ff + 32'(x2_ff);
               sxxx_in  = sxxx_ff + 44'(x3);
               sxxxx_in = sxxxx_ff + 56'(x4);
               sy_in    = sy_ff + 24'(y_ff);
               sxy_in   = sxy_ff + 36'(xy_ff);
               sxxy_in  = sxxy_ff + 48'(x2y);
            end
            if (last_ff) begin
               k_in     = 2'd0;
               step_in  = '0;
               a2_in    = '0;
               a1_in    = '0;
               a0_in    = '0;
               sat_in   = 1'b0;
               sing_in  = 1'b0;
               state_in = S_MSTART;
            end else if (item_valid) begin
               item_take = 1'b1;
               x_in      = item.x_value;
               y_in      = item.y_value;
               last_in   = item.last;
               state_in  = S_ACC1;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_MSTART: begin
            mdu_req.start  = 1'b1;
            mdu_req.is_div = 1'b0;
            mdu_req.a      = b_neg ? (128'd0 - a_src) : a_src;
            mdu_req.b      = 128'(b_mag);
            state_in       = S_MWAIT;
         end
         S_MWAIT: begin
            if (mdu_rsp.done) begin
               case (cur.op)
                  OP_C_SET: cof_in = prod;
                  OP_C_SUB: cof_in = cof_ff - prod;
                  OP_D_SET: det_in = prod;
                  OP_D_SUB: det_in = det_ff - prod;
                  OP_D_ADD: det_in = det_ff + prod;
                  default:  det_in = det_ff;
               endcase
               if (step_ff == STEP_W'(NUM_STEPS - 1)) begin
                  state_in = (k_ff == 2'd0) ? S_DABS : S_NABS;
               end else begin
                  step_in  = step_ff + 1'b1;
                  state_in = S_MSTART;
               end
            end
         end
         S_DABS: begin
            dneg_in  = det_ff[WIDE_W-1];
            dabs_in  = det_ff[WIDE_W-1] ? (128'd0 - det_ff) : det_ff;
            state_in = S_DCHK;
         end
         S_DCHK: begin
            if ((dabs_ff[WIDE_W-1:32] == '0) && (dabs_ff[31:0] <= det_threshold)) begin
               sing_in  = 1'b1;
               state_in = S_EMIT;
            end else begin
               k_in     = 2'd1;
               step_in  = '0;
               state_in = S_MSTART;
            end
         end
         S_NABS: begin
            mdu_req.start  = 1'b1;
            mdu_req.is_div = 1'b1;
            mdu_req.a      = dabs_ff;
            mdu_req.b      = num[WIDE_W-1] ? (128'd0 - num) : num;
            qneg_in        = num[WIDE_W-1] ^ dneg_ff;
            state_in       = S_DWAIT;
         end
         S_DWAIT: begin
            if (mdu_rsp.done) begin
               sat_in = sat_ff | csat;
               case (k_ff)
                  2'd1:    a2_in = cval;
                  2'd2:    a1_in = cval;
                  default: a0_in = cval;
               endcase
               if (k_ff == 2'd3) begin
                  state_in = S_EMIT;
               end else begin
                  k_in     = k_ff + 2'd1;
                  step_in  = '0;
                  state_in = S_MSTART;
               end
            end
         end
         S_EMIT: begin
            res_valid = 1'b1;
            if (res_free) begin
               cnt_in   = '0;
               sx_in    = '0; sxx_in = '0; sxxx_in = '0; sxxxx_in = '0;
               sy_in    = '0; sxy_in = '0; sxxy_in = '0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign res_item.coef_a2   = a2_ff;
   assign res_item.coef_a1   = a1_ff;
   assign res_item.coef_a0   = a0_ff;
   assign res_item.singular  = sing_ff;
   assign res_item.saturated = sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         sx_ff    <= '0; sxx_ff <= '0; sxxx_ff <= '0; sxxxx_ff <= '0;
         sy_ff    <= '0; sxy_ff <= '0; sxxy_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         sx_ff    <= sx_in;  sxx_ff <= sxx_in;  sxxx_ff <= sxxx_in;  sxxxx_ff <= sxxxx_in;
         sy_ff    <= sy_in;  sxy_ff <= sxy_in;  sxxy_ff <= sxxy_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;    y_ff    <= y_in;    last_ff <= last_in;
      x2_ff   <= x2_in;   xy_ff   <= xy_in;
      k_ff    <= k_in;    step_ff <= step_in;
      cof_ff  <= cof_in;  det_ff  <= det_in;
      dabs_ff <= dabs_in; dneg_ff <= dneg_in; qneg_ff <= qneg_in;
      a2_ff   <= a2_in;   a1_ff   <= a1_in;   a0_ff   <= a0_in;
      sat_ff  <= sat_in;  sing_ff <= sing_in;
   end

endmodule

FILE: rtl/core/quadratic_least_squares_fit_unit.sv
// top level of the quadratic least-squares fit unit: front queue, back end, shared mdu
// depends on qlsf_pkg, qlsf_front, qlsf_back and qlsf_mdu
//
// sample words (x in q8.4, y in q8.8) are pushed while full is low and land in a
// four-word queue; the back end takes each word through an accumulate state for
// x*x and x*y and then one for the higher products and the sums, so up to four words
// ride in while it is busy. a word with last set starts the solve: the four 3x3
// determinants are built by cofactor expansion on one shared shift-add multiplier
// (36 products) and feed three 128-bit restoring divides; when the first
// determinant falls at or below det_threshold, the solve stops there and the set
// is reported singular. during the solve no words leave the queue. one result word
// waits in the output register until popped; meanwhile a finished result holds the
// back end, which takes no new words until the output register is free
module quadratic_least_squares_fit_unit #(
   parameter int MAX_POINTS = qlsf_pkg::MAX_POINTS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  qlsf_pkg::req_item_type req_item,
   output logic                   empty,
   input  logic                   pop,
   output qlsf_pkg::rsp_item_type rsp_item,
   input  logic                   csr_wr_en,
   input  logic [31:0]            csr_wr_data
);
   import qlsf_pkg::*;

   // singularity threshold register
   logic [31:0]  thr_ff, thr_in;

   // output register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;

   // front to back
   logic         head_valid;
   req_item_type head_item;
   logic         take;

   // back to output register
   logic         res_valid;
   rsp_item_type res_item;
   logic         out_free;

   // back to shared multiply/divide unit
   mdu_req_type  mdu_req;
   mdu_rsp_type  mdu_rsp;

   qlsf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_item   (req_item),
      .head_valid (head_valid),
      .head_item  (head_item),
      .take       (take)
   );

   qlsf_back #(
      .MAX_POINTS (MAX_POINTS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (head_valid),
      .item          (head_item),
      .item_take     (take),
      .det_threshold (thr_ff),
      .mdu_req       (mdu_req),
      .mdu_rsp       (mdu_rsp),
      .res_valid     (res_valid),
      .res_item      (res_item),
      .res_free      (out_free)
   );

   qlsf_mdu u_mdu (
      .clock (clock),
      .reset (reset),
      .req   (mdu_req),
      .rsp   (mdu_rsp)
   );

   // output slot is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || pop;
   assign empty    = !rsp_valid_ff;
   assign rsp_item = rsp_item_ff;

   always_comb begin
      thr_in       = csr_wr_en ? csr_wr_data : thr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (res_valid && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = res_item;
      end else if (pop && rsp_valid_ff) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         thr_ff       <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   // a singular result carries zero coefficients and no clipping
   assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_item.singular) |->
         (rsp_item.coef_a2 == 32'sd0 && rsp_item.coef_a1 == 32'sd0 &&
          rsp_item.coef_a0 == 32'sd0 && !rsp_item.saturated))
      else $error("singular result with nonzero coefficients");

   // clipping shows up as a rail value in at least one coefficient
   assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_item.saturated) |->
         (rsp_item.coef_a2 == SAT_POS || rsp_item.coef_a2 == SAT_NEG ||
          rsp_item.coef_a1 == SAT_POS || rsp_item.coef_a1 == SAT_NEG ||
          rsp_item.coef_a0 == SAT_POS || rsp_item.coef_a0 == SAT_NEG))
      else $error("saturated flag without a clipped coefficient");

   // the output register only fills from a finished solve
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(res_valid))
      else $error("result word appeared without a finished solve");

endmodule

FILE: dv/qlsf_fit_checker.sv
// checker for the quadratic fit unit: watches the sample, result and csr channels
// predicts each result word from its own copy of the sums and compares it; depends on qlsf_pkg
module qlsf_fit_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic                   full,
   input  qlsf_pkg::req_item_type req_item,
   input  logic                   empty,
   input  logic                   pop,
   input  qlsf_pkg::rsp_item_type rsp_item,
   input  logic                   csr_wr_en,
   input  logic [31:0]            csr_wr_data,
   output int                     fail_count,
   output int                     fits_waiting,
   output int                     fits_seen,
   output int                     singular_seen,
   output int                     saturated_seen
);
   timeunit 1ns;
   timeprecision 1ps;
   import qlsf_pkg::*;

   localparam int POINT_LIMIT = MAX_POINTS_DEF;

   typedef logic signed [127:0] wide_t;

   rsp_item_type fits_due[$];
   logic [31:0]  thr;
   int           npts;
   longint       s_x, s_xx, s_xxx, s_xxxx, s_y, s_xy, s_xxy;

   assign fits_waiting = fits_due.size();

   function automatic wide_t det3(input wide_t a, b, c, d, e, f, g, h, i);
      return a * (e * i - f * h) - b * (d * i - f * g) + c * (d * h - e * g);
   endfunction

   function automatic logic [31:0] to_q16(input wide_t num, input wide_t den,
                                          input int shift, inout logic sat);
      wide_t       n;
      logic [127:0] an, ad, q;
      logic        neg;
      n   = num <<< shift;
      neg = n[127] != den[127];
      an  = n[127] ? -n : n;
      ad  = den[127] ? -den : den;
      q   = an / ad;
      if (!neg) begin
         if (q > 128'h7FFF_FFFF) begin
            sat = 1'b1;
            return SAT_POS;
         end
         return q[31:0];
      end
      if (q > 128'h8000_0000) begin
         sat = 1'b1;
         return SAT_NEG;
      end
      return -q[31:0];
   endfunction

   // solve the normal equations over the current sums
   function automatic rsp_item_type solve_fit();
      rsp_item_type r;
      wide_t        m00, m01, m02, m11, m12, m22, b0, b1, b2, dd, ad;
      logic         sat;
      r   = '0;
      sat = 1'b0;
      m00 = s_xxxx; m01 = s_xxx; m02 = s_xx; m11 = s_xx; m12 = s_x; m22 = npts;
      b0  = s_xxy;  b1 = s_xy;   b2 = s_y;
      dd  = det3(m00, m01, m02, m01, m11, m12, m02, m12, m22);
      ad  = dd[127] ? -dd : dd;
      r.singular = ad <= wide_t'({96'd0, thr});
      if (!r.singular) begin
         r.coef_a2 = to_q16(det3(b0, m01, m02, b1, m11, m12, b2, m12, m22), dd, 16, sat);
         r.coef_a1 = to_q16(det3(m00, b0, m02, m01, b1, m12, m02, b2, m22), dd, 12, sat);
         r.coef_a0 = to_q16(det3(m00, m01, b0, m01, m11, b1, m02, m12, b2), dd, 8, sat);
      end
      r.saturated = sat;
      return r;
   endfunction

   always @(posedge clock) begin
      longint       x, y;
      rsp_item_type want;
      if (reset) begin
         thr <= '0;
         npts = 0;
         {s_x, s_xx, s_xxx, s_xxxx, s_y, s_xy, s_xxy} = '0;
         fail_count <= 0;
         fits_seen <= 0;
         singular_seen <= 0;
         saturated_seen <= 0;
      end else begin
         if (csr_wr_en)
            thr <= csr_wr_data;
         if (push && !full) begin
            x = req_item.x_value;
            y = req_item.y_value;
            if (npts < POINT_LIMIT) begin
               npts++;
               s_x += x; s_xx += x * x; s_xxx += x * x * x; s_xxxx += x * x * x * x;
               s_y += y; s_xy += x * y; s_xxy += x * x * y;
            end
            if (req_item.last) begin
               fits_due = {fits_due, solve_fit()};
               npts = 0;
               {s_x, s_xx, s_xxx, s_xxxx, s_y, s_xy, s_xxy} = '0;
            end
         end
         if (pop && !empty) begin
            if (fits_due.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected result word %h", rsp_item);
               fail_count <= fail_count + 1;
            end else begin
               want = fits_due.pop_front();
               fits_seen <= fits_seen + 1;
               singular_seen <= singular_seen + want.singular;
               saturated_seen <= saturated_seen + want.saturated;
               if (rsp_item !== want) begin
                  if (fail_count < 10)
                     $display("fit mismatch: a2 %h/%h a1 %h/%h a0 %h/%h sing %b/%b sat %b/%b",
                              want.coef_a2, rsp_item.coef_a2, want.coef_a1, rsp_item.coef_a1,
                              want.coef_a0, rsp_item.coef_a0, want.singular, rsp_item.singular,
                              want.saturated, rsp_item.saturated);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

FILE: dv/tb_quadratic_least_squares_fit_unit.sv
// top of the quadratic fit unit testbench: clock, reset, sample stimulus and verdict
// depends on qlsf_pkg, quadratic_least_squares_fit_unit and qlsf_fit_checker
module tb_quadratic_least_squares_fit_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import qlsf_pkg::*;

   localparam int     SOLVE_CYCLES = 3000;     // worst solve plus margin
   localparam longint CYCLE_LIMIT  = 4000000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         push = 1'b0;
   logic         full, empty;
   logic         pop = 1'b0;
   req_item_type req_item = '0;
   rsp_item_type rsp_item;
   logic         csr_wr_en = 1'b0;
   logic [31:0]  csr_wr_data = '0;

   int     fail_count, fits_waiting, fits_seen, singular_seen, saturated_seen;
   int     words_sent;
   int     burst_left;
   longint cycle_count = 0;

   always #5 clock = ~clock;

   quadratic_least_squares_fit_unit uut (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_item(req_item),
      .empty(empty), .pop(pop), .rsp_item(rsp_item),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   qlsf_fit_checker checker_i (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_item(req_item),
      .empty(empty), .pop(pop), .rsp_item(rsp_item),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .fail_count(fail_count), .fits_waiting(fits_waiting), .fits_seen(fits_seen),
      .singular_seen(singular_seen), .saturated_seen(saturated_seen)
   );

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // receiver: pops freely, at random, or in long stalls, stepping through the modes in turn
   always @(posedge clock) begin
      case ((cycle_count / 3000) % 3)
         0: pop <= 1'b1;
         1: pop <= 1'($urandom_range(0, 1));
         default: pop <= ($urandom_range(0, 15) == 0);
      endcase
   end

   // one sample word; push stays high if the next word follows straight on
   task automatic send_word(input int x, input int y, input bit last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = $urandom_range(0, 12);
         if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      push <= 1'b1;
      req_item <= '{x_value: x[11:0], y_value: y[15:0], last: last};
      do @(posedge clock); while (full);
      words_sent++;
   endtask

   // set of n points ended by last; shape picks how the x values are spread and whether y lies on a parabola
   task automatic send_set(input int n, input int shape);
      int x, y, a, b, c;
      a = $urandom_range(0, 15) - 8;
      b = $urandom_range(0, 63) - 32;
      c = $urandom_range(0, 2047) - 1024;
      for (int k = 0; k < n; k++) begin
         case (shape)
            0: x = $urandom_range(0, 4095) - 2048;
            1: x = $urandom_range(0, 16) - 8;            // tight spread, small determinant
            2: x = (k % 2) ? 100 : -37;                  // two distinct x only
            default: x = $urandom_range(0, 255) - 128;
         endcase
         if (shape == 3)
            y = (a * x * x) / 16 + b * x + c;            // noiseless parabola
         else
            y = $urandom_range(0, 65535) - 32768;
         if (y > 32767) y = 32767;
         if (y < -32768) y = -32768;
         send_word(x, y, k == n - 1);
      end
   endtask

   // wait until every result word has come back, then let the solver go quiet
   task automatic drain();
      push <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (fits_waiting != 0);
      repeat (SOLVE_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [31:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int n, pick, phase;
      words_sent = 0;
      burst_left = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: threshold zero
      write_threshold(32'd0);
      send_word(0, 0, 1'b1);                        // last on a single point
      send_word(5, 7, 1'b0);                        // two distinct x: singular
      send_word(9, -7, 1'b1);
      send_word(-2048, -32768, 1'b0);               // field extremes
      send_word(2047, 32767, 1'b0);
      send_word(0, 0, 1'b0);
      send_word(2047, -32768, 1'b1);
      send_word(0, 32767, 1'b0);                    // steep curve over tiny x: clips
      send_word(1, -32768, 1'b0);
      send_word(2, 32767, 1'b1);
      send_set(6, 3);
      send_set(5, 1);
      drain();

      // directed: top threshold, with an overflow of the point store
      write_threshold(32'hFFFF_FFFF);
      send_set(260, 0);
      send_set(8, 1);
      send_set(4, 2);
      drain();

      // random phases with a fresh threshold each time
      phase = 0;
      while (words_sent < 1250) begin
         case (phase % 4)
            0: write_threshold(32'd0);
            1: write_threshold(32'hFFFF_FFFF);
            2: write_threshold($urandom_range(1, 100000));
            default: write_threshold($urandom());
         endcase
         for (int s = 0; s < 40 && words_sent < 1250; s++) begin
            pick = $urandom_range(0, 99);
            if (pick < 4)       n = $urandom_range(1, 2);
            else if (pick < 92) n = $urandom_range(3, 12);
            else if (pick < 99) n = $urandom_range(13, 60);
            else                n = $urandom_range(250, 270);
            send_set(n, $urandom_range(0, 3));
         end
         drain();
         phase++;
      end

      $display("sent %0d sample words, checked %0d fits (%0d singular, %0d clipped)",
               words_sent, fits_seen, singular_seen, saturated_seen);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
